// ===== hdl/config_record_verifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for config_record_verifier
// Concurrent checks on clk, disabled while arst_n is low. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CONFIG_RECORD_VERIFIER_ASSERT_SVH
`define CONFIG_RECORD_VERIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define CRV_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crv assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define CRV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crv assertion failed");
`else
`define CRV_ASSERT_SAME(label, ante, cons)
`define CRV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/crv_pkg.sv =====
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types, codes and the byte-wide CRC-32 update for the record checker.
// ----------------------------------------------------------------------------
package crv_pkg;

	localparam int unsigned CfgIndexWidth = 1;
	localparam int unsigned CfgDataWidth  = 32;
	localparam int unsigned PosWidth      = 17;

	// register indexes
	localparam logic [CfgIndexWidth-1:0] CfgBlobLength = 1'd0;
	localparam logic [CfgIndexWidth-1:0] CfgMagicWord  = 1'd1;

	localparam logic [15:0] BlobLengthReset = 16'd1024;
	localparam logic [31:0] MagicWordReset  = 32'd1397902420;

	// verdict codes
	localparam logic [1:0] StatusValid     = 2'd0;
	localparam logic [1:0] StatusMagicBad  = 2'd1;
	localparam logic [1:0] StatusLengthBad = 2'd2;
	localparam logic [1:0] StatusCrcBad    = 2'd3;

	localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;
	localparam int unsigned CrcBitsPerByte = 8;

	localparam logic [PosWidth-1:0] HeaderBytes = 17'd6;
	localparam logic [PosWidth-1:0] TailBytes   = 17'd4;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [31:0] crc;
	} crv_result_t;

	// reflected CRC-32, one byte, eight bit steps unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] r;
		r = crc ^ {24'd0, data};
		for (int k = 0; k < CrcBitsPerByte; k++) begin
			r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

// ===== hdl/crv_core.sv =====
// ----------------------------------------------------------------------------
// crv_core
// Record parse state and CRC register; one byte per step, verdict alongside.
// ----------------------------------------------------------------------------
`include "config_record_verifier_assert.svh"

module crv_core
	import crv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [15:0] blob_length,
	input  logic [31:0] magic_word,
	output crv_result_t result
);

	logic [PosWidth-1:0] pos_q, pos_e, pos_n;
	logic [31:0]         crc_q, crc_e, crc_n, crc_b, crc_fin;
	logic                mok_q, mok_e, mok_n;
	logic [7:0]          len_lo_q, len_lo_e, len_lo_n;
	logic [31:0]         shift_q, shift_e, shift_n;
	logic                vg_q, vg_e, vg_n;
	logic [PosWidth-1:0] blob_end, tail_last;
	logic [7:0]          want;

	assign blob_end  = {1'b0, blob_length} + HeaderBytes;
	assign tail_last = blob_end + TailBytes - 17'd1;

	always_comb begin
		// a first-byte mark restarts the record
		pos_e    = first_byte ? '0 : pos_q;
		crc_e    = first_byte ? '1 : crc_q;
		mok_e    = first_byte ? 1'b1 : mok_q;
		len_lo_e = first_byte ? '0 : len_lo_q;
		shift_e  = first_byte ? '0 : shift_q;
		vg_e     = first_byte ? 1'b0 : vg_q;

		pos_n    = pos_e;
		crc_n    = crc_e;
		mok_n    = mok_e;
		len_lo_n = len_lo_e;
		shift_n  = shift_e;
		vg_n     = vg_e;
		result   = '0;

		crc_b   = crc_byte(crc_e, data_byte);
		crc_fin = ~crc_e;
		want    = 8'(magic_word >> {pos_e[1:0], 3'b000});

		if (!vg_e) begin
			pos_n = pos_e + 17'd1;
			if (pos_e < 17'd4) begin
				mok_n = mok_e && (data_byte == want);
				crc_n = crc_b;
				if (pos_e == 17'd3 && !mok_n) begin
					result = '{valid: 1'b1, status: StatusMagicBad, crc: '0};
					vg_n   = 1'b1;
				end
			end else if (pos_e == 17'd4) begin
				len_lo_n = data_byte;
				crc_n    = crc_b;
			end else if (pos_e == 17'd5) begin
				crc_n = crc_b;
				if ({data_byte, len_lo_e} != blob_length) begin
					result = '{valid: 1'b1, status: StatusLengthBad, crc: '0};
					vg_n   = 1'b1;
				end
			end else if (pos_e < blob_end) begin
				crc_n = crc_b;
			end else begin
				// stored CRC is little-endian: shift in from the top
				shift_n = {data_byte, shift_e[31:8]};
				if (pos_e >= tail_last) begin
					result = '{valid: 1'b1,
						status: (crc_fin == shift_n) ? StatusValid : StatusCrcBad,
						crc: crc_fin};
					vg_n   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= '1;
			mok_q    <= 1'b1;
			len_lo_q <= '0;
			shift_q  <= '0;
			vg_q     <= 1'b1;
		end else if (step) begin
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			mok_q    <= mok_n;
			len_lo_q <= len_lo_n;
			shift_q  <= shift_n;
			vg_q     <= vg_n;
		end
	end

	// a verdict closes the record until the next mark
	`CRV_ASSERT_NEXT(a_verdict_closes, step && result.valid, vg_q)
	// nothing is reported while idle without a mark
	`CRV_ASSERT_SAME(a_idle_silent, vg_q && !first_byte, !result.valid)
	// the position never runs past the last CRC byte of the longest record
	`CRV_ASSERT_SAME(a_pos_bound, !vg_q,
		pos_q <= {1'b0, 16'hFFFF} + HeaderBytes + TailBytes - 17'd1)

endmodule

// ===== hdl/config_record_verifier.sv =====
// ----------------------------------------------------------------------------
// config_record_verifier
// Streams a stored settings record and gives one verdict per record.
// ----------------------------------------------------------------------------
// One byte is taken per transfer; the block sustains one byte every clock
// cycle unless out_stall holds a full result register, and returns a
// verdict via one input and one result register. Throughput is set by
// the CRC-32 update; its eight bit steps run combinationally between the two
// registers. A record is magic (4 bytes), little-endian length (2 bytes),
// blob, little-endian CRC-32. A byte with first_byte set starts a record;
// status 1 comes after the fourth byte on a magic mismatch, status 2 after
// the sixth on a length mismatch (computed_crc is zero for both), otherwise
// status 0 or 3 after the last CRC byte with the computed CRC. Bytes after a
// verdict are dropped until the next first_byte. Registers: index 0 is
// blob_length, index 1 is magic_word (first byte in bits 7..0); write them
// only while the block is idle.
// ----------------------------------------------------------------------------
`include "config_record_verifier_assert.svh"

module config_record_verifier
	import crv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	// byte stream
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               data_byte,
	input  logic                     first_byte,
	// verdicts
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [31:0]              computed_crc
);

	logic [15:0]  blob_length_q;
	logic [31:0]  magic_word_q;

	// input register stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         first_s1;

	// result register
	logic         out_valid_q;
	logic [1:0]   status_q;
	logic [31:0]  crc_q;

	logic         res_free;
	logic         adv_s1;
	logic         in_take;
	crv_result_t  res;

	// Result register is free when empty or being taken this cycle.
	assign res_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && res_free;
	// Stage 1 can take a byte whenever it is empty or moving on.
	assign in_stall = valid_s1 && !res_free;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_length_q <= BlobLengthReset;
			magic_word_q  <= MagicWordReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgBlobLength: blob_length_q <= cfg_data[15:0];
				CfgMagicWord:  magic_word_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	// parse state, CRC and verdict logic
	crv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.data_byte   (byte_s1),
		.first_byte  (first_s1),
		.blob_length (blob_length_q),
		.magic_word  (magic_word_q),
		.result      (res)
	);

	// result register: loads a verdict, clears once its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= adv_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			status_q <= res.status;
			crc_q    <= res.crc;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign computed_crc = crc_q;

	// early failures carry a zero CRC
	`CRV_ASSERT_SAME(a_early_zero_crc,
		out_valid && (status == StatusMagicBad || status == StatusLengthBad),
		computed_crc == 32'd0)
	// a verdict from stage 1 always lands in the result register
	`CRV_ASSERT_NEXT(a_verdict_lands, adv_s1 && res.valid, out_valid)
	// a new verdict only follows a byte held in stage 1
	`CRV_ASSERT_SAME(a_verdict_source, $rose(out_valid_q), $past(valid_s1))

endmodule
